>>> rtl/core/fir_filter_pwm_mirror_macros.svh
// ---------------------------------------------------------------------------
// fir_filter_pwm_mirror_macros
// Assertion macros shared by the filter RTL.
// ---------------------------------------------------------------------------
`ifndef FIR_FILTER_PWM_MIRROR_MACROS_SVH
`define FIR_FILTER_PWM_MIRROR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FFPM_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FFPM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ffpm_pkg.sv
// ---------------------------------------------------------------------------
// ffpm_pkg
// Types, constants and coefficient table of the symmetric FIR / PWM block.
// ---------------------------------------------------------------------------
package ffpm_pkg;

  localparam int SampleW  = 16;
  localparam int BaseTaps = 32;

  // x/5 for x < 2^16: (x * 0xCCCD) >> 18
  localparam logic [SampleW-1:0] Div5Mul   = 16'hCCCD;
  localparam int                 Div5Shift = 18;

  // register decode on paddr[2]
  localparam logic RegPwmCenter      = 1'b0;
  localparam logic RegLevelThreshold = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic [SampleW-1:0] pwm_center;
    logic [SampleW-1:0] level_threshold;
  } cfg_t;

  localparam logic signed [15:0] CoefQ15 [BaseTaps] = '{
     16'sd477,   16'sd101,   -16'sd11,  -16'sd204,
    -16'sd442,  -16'sd666,  -16'sd797,  -16'sd754,
    -16'sd475,    16'sd68,   16'sd855,  16'sd1817,
    16'sd2837,  16'sd3777,  16'sd4499,  16'sd4891,
    16'sd4891,  16'sd4499,  16'sd3777,  16'sd2837,
    16'sd1817,   16'sd855,    16'sd68,  -16'sd475,
    -16'sd754,  -16'sd797,  -16'sd666,  -16'sd442,
    -16'sd204,   -16'sd11,   16'sd101,   16'sd477
  };

  // Q15 tap rescaled to frac fractional bits, ties away from zero
  function automatic logic signed [31:0] coef_scaled(input int k, input int frac);
    int c;
    int mag;
    int sh;
    logic neg;
    if (k >= BaseTaps) begin
      return '0;
    end
    c = int'(CoefQ15[k]);
    if (frac >= 15) begin
      return 32'(c <<< (frac - 15));
    end
    sh  = 15 - frac;
    neg = (c < 0);
    mag = neg ? -c : c;
    mag = (mag + (1 << (sh - 1))) >> sh;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

endpackage

>>> rtl/core/ffpm_sample_if.sv
// ---------------------------------------------------------------------------
// ffpm_sample_if
// Valid/ready channel carrying one raw converter word.
// ---------------------------------------------------------------------------
interface ffpm_sample_if;
  import ffpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink   (input valid, input sample_word, output ready);
endinterface

>>> rtl/core/ffpm_result_if.sv
// ---------------------------------------------------------------------------
// ffpm_result_if
// Valid/ready channel carrying the filter output, PWM compares and level flag.
// ---------------------------------------------------------------------------
interface ffpm_result_if;
  import ffpm_pkg::*;

  logic               valid;
  logic               ready;
  sample_t            filtered_sample;
  logic [SampleW-1:0] compare_high;
  logic [SampleW-1:0] compare_low;
  logic               over_level;

  modport source (output valid, output filtered_sample, output compare_high,
                  output compare_low, output over_level, input ready);
  modport sink   (input valid, input filtered_sample, input compare_high,
                  input compare_low, input over_level, output ready);
endinterface

>>> rtl/core/fir_filter_pwm_mirror.sv
// ---------------------------------------------------------------------------
// fir_filter_pwm_mirror
// Symmetric FIR on offset-binary samples with mirrored PWM compares and a
// level flag, built as a systolic row of tap cells.
//
//   channel   dir  handshake        payload
//   sample_i  in   valid/ready      sample_word
//   result_o  out  valid/ready      filtered_sample, compare_high,
//                                   compare_low, over_level
//   apb       in   psel/penable     paddr, pwdata -> prdata (pready high)
//
// One request per clock sustained while result_o.ready holds.
// The tap row and sample stage advance only on an accepted request, so the
// partial sums stay exact under any stall pattern.
// Reset clears the partial sums (an all-zero delay line) and loads the
// register defaults; no clearing pass.
// Downstream stall: the output register and the sample stage fill, then
// ready drops.
// ---------------------------------------------------------------------------
`include "fir_filter_pwm_mirror_macros.svh"

module fir_filter_pwm_mirror #(
  parameter int TAPS           = 32,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffpm_sample_if.sink  sample_i,
  ffpm_result_if.source result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ffpm_pkg::*;

  localparam int CoefW = (COEF_FRAC_BITS > 15) ? SampleW + COEF_FRAC_BITS - 15 : SampleW;
  localparam int AccW  = SampleW + CoefW + $clog2(TAPS);
  localparam logic signed [AccW-1:0] SatMax = AccW'(32767);
  localparam logic signed [AccW-1:0] SatMin = -SatMax - AccW'(1);
  localparam logic signed [AccW-1:0] TruncBias =
    {{(AccW-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};

  cfg_t cfg;

  ffpm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake
  logic out_valid_q;
  logic s1_valid_q;
  logic out_take;
  logic s1_take;
  logic in_fire;

  assign out_take       = !out_valid_q || result_o.ready;
  assign s1_take        = !s1_valid_q || out_take;
  assign sample_i.ready = s1_take;
  assign in_fire        = sample_i.valid && s1_take;

  // tap row
  sample_t                sample;
  logic signed [AccW-1:0] chain_sum [TAPS+1];

  assign sample          = sample_t'(sample_i.sample_word ^ 16'h8000);
  assign chain_sum[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    ffpm_tap_cell #(
      .CoefW (CoefW),
      .AccW  (AccW),
      .Coef  (CoefW'(coef_scaled(k, COEF_FRAC_BITS)))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (in_fire),
      .sample_i (sample),
      .sum_i    (chain_sum[k+1]),
      .sum_o    (chain_sum[k])
    );
  end

  // sample stage: divide by five, level compare
  logic                   neg;
  logic [SampleW-1:0]     mag;
  logic [2*SampleW-1:0]   div_prod;
  logic [SampleW-1:0]     quot_mag;
  sample_t                quot_d;
  sample_t                quot_q;
  logic                   over_d;
  logic                   over_q;

  assign neg      = sample[SampleW-1];
  assign mag      = neg ? SampleW'(-sample) : SampleW'(sample);
  assign div_prod = mag * Div5Mul;
  assign quot_mag = SampleW'(div_prod[2*SampleW-1:Div5Shift]);
  assign quot_d   = neg ? sample_t'(-quot_mag) : sample_t'(quot_mag);
  assign over_d   = sample > $signed(cfg.level_threshold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_take) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      quot_q <= quot_d;
      over_q <= over_d;
    end
  end

  // output stage: truncate toward zero, saturate, mirror compares
  logic signed [AccW-1:0] acc_biased;
  logic signed [AccW-1:0] acc_shift;
  sample_t                filt_d;
  sample_t                filt_q;
  logic [SampleW-1:0]     cmp_hi_d;
  logic [SampleW-1:0]     cmp_lo_d;
  logic [SampleW-1:0]     cmp_hi_q;
  logic [SampleW-1:0]     cmp_lo_q;
  logic                   flag_q;

  assign acc_biased = chain_sum[0] + (chain_sum[0][AccW-1] ? TruncBias : '0);
  assign acc_shift  = acc_biased >>> COEF_FRAC_BITS;

  always_comb begin
    priority if (acc_shift > SatMax) begin
      filt_d = sample_t'(SatMax);
    end else if (acc_shift < SatMin) begin
      filt_d = sample_t'(SatMin);
    end else begin
      filt_d = sample_t'(acc_shift);
    end
  end

  assign cmp_hi_d = cfg.pwm_center + SampleW'(quot_q);
  assign cmp_lo_d = cfg.pwm_center - SampleW'(quot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_valid_q) begin
      filt_q   <= filt_d;
      cmp_hi_q <= cmp_hi_d;
      cmp_lo_q <= cmp_lo_d;
      flag_q   <= over_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.filtered_sample = filt_q;
  assign result_o.compare_high    = cmp_hi_q;
  assign result_o.compare_low     = cmp_lo_q;
  assign result_o.over_level      = flag_q;

  `FFPM_ASSERT_NEXT(a_fire_fills_s1, clk_i, rst_ni, in_fire, s1_valid_q, "request lost")
  `FFPM_ASSERT_NOW(a_stall_full, clk_i, rst_ni, !sample_i.ready, s1_valid_q && out_valid_q && !result_o.ready, "ready dropped with room")
  `FFPM_ASSERT_NEXT(a_s1_hold_sum, clk_i, rst_ni, s1_valid_q && !out_take, s1_valid_q && $stable(chain_sum[0]), "pending sum overwritten")
  `FFPM_ASSERT_NEXT(a_drain, clk_i, rst_ni, out_valid_q && result_o.ready && !s1_valid_q, !out_valid_q, "result repeated")

endmodule

>>> rtl/core/ffpm_tap_cell.sv
// ---------------------------------------------------------------------------
// ffpm_tap_cell
// One transposed-form FIR cell: multiply the broadcast sample by a fixed tap
// and add the partial sum handed over by the upstream neighbor.
// ---------------------------------------------------------------------------
module ffpm_tap_cell #(
  parameter int                        CoefW = 16,
  parameter int                        AccW  = 37,
  parameter logic signed [CoefW-1:0]   Coef  = '0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ffpm_pkg::sample_t      sample_i,
  input  logic signed [AccW-1:0] sum_i,
  output logic signed [AccW-1:0] sum_o
);
  import ffpm_pkg::*;

  logic signed [CoefW+SampleW-1:0] prod;
  logic signed [AccW-1:0]          sum_d;
  logic signed [AccW-1:0]          sum_q;

  assign prod  = sample_i * Coef;
  assign sum_d = sum_i + AccW'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule

>>> rtl/core/ffpm_cfg_regs.sv
// ---------------------------------------------------------------------------
// ffpm_cfg_regs
// APB register file: PWM center and over-level threshold.
// ---------------------------------------------------------------------------
module ffpm_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ffpm_pkg::cfg_t      cfg_o
);
  import ffpm_pkg::*;

  logic [SampleW-1:0] center_q;
  logic [SampleW-1:0] thresh_q;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= 16'd7500;
      thresh_q <= 16'd14000;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegPwmCenter:      center_q <= pwdata[SampleW-1:0];
        RegLevelThreshold: thresh_q <= pwdata[SampleW-1:0];
        default:           center_q <= center_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPwmCenter:      prdata = {16'b0, center_q};
      RegLevelThreshold: prdata = {{16{thresh_q[SampleW-1]}}, thresh_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.pwm_center      = center_q;
  assign cfg_o.level_threshold = thresh_q;
endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the symmetric FIR / mirrored PWM compare block.
// Offset-binary sample requests drive a bit-true model of the 32-tap delay
// line, compare values and level flag. Every result is checked against it,
// under random gaps on both channels and register settings written over APB.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffpm_pkg::*;

  localparam int NumTaps     = 32;
  localparam int FracBits    = 15;
  localparam int IdleLimit   = 3000;
  localparam int LongHold    = 300;

  localparam logic [2:0] AddrPwmCenter      = {RegPwmCenter, 2'b00};
  localparam logic [2:0] AddrLevelThreshold = {RegLevelThreshold, 2'b00};

  localparam int FirCoef [NumTaps] = '{
     477,   101,   -11,  -204,  -442,  -666,  -797,  -754,
    -475,    68,   855,  1817,  2837,  3777,  4499,  4891,
    4891,  4499,  3777,  2837,  1817,   855,    68,  -475,
    -754,  -797,  -666,  -442,  -204,   -11,   101,   477
  };

  typedef struct packed {
    sample_t            filtered_sample;
    logic [SampleW-1:0] compare_high;
    logic [SampleW-1:0] compare_low;
    logic               over_level;
  } fir_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffpm_sample_if sample_ch ();
  ffpm_result_if result_ch ();

  fir_filter_pwm_mirror #(
    .TAPS           (NumTaps),
    .COEF_FRAC_BITS (FracBits)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [SampleW-1:0]        sample_words_q[$];
  fir_result_t               predicted_q[$];
  logic [SampleW-1:0]        center_shadow    = 16'd7500;
  logic signed [SampleW-1:0] threshold_shadow = 16'sd14000;
  int                        tap_hist [NumTaps] = '{default: 0};
  bit                        req_taken;
  bit                        no_idle;
  int                        send_gap;
  int                        stall_left;
  int                        hold_left;
  int                        hold_req;
  int                        hold_ack;
  int                        idle_cycles;
  int                        mismatch_cnt;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fir_result_t filter_and_compare(input logic [SampleW-1:0] word);
    fir_result_t res;
    int          s;
    int          q;
    longint      acc;
    longint      mag;
    longint      y;
    s = int'(word) - 32768;
    for (int k = NumTaps - 1; k > 0; k--) tap_hist[k] = tap_hist[k-1];
    tap_hist[0] = s;
    acc = 0;
    for (int k = 0; k < NumTaps; k++) acc += longint'(FirCoef[k]) * longint'(tap_hist[k]);
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> FracBits;
    y   = (acc < 0) ? -mag : mag;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    q = s / 5;
    res.filtered_sample = sample_t'(y[15:0]);
    res.compare_high    = 16'(int'(center_shadow) + q);
    res.compare_low     = 16'(int'(center_shadow) - q);
    res.over_level      = (s > int'(threshold_shadow));
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (sample_words_q.size() != 0 || sample_ch.valid || predicted_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_burst(input int n);
    int                 cnt;
    int                 kind;
    int                 len;
    int                 s;
    logic [SampleW-1:0] level;
    logic [SampleW-1:0] extremes [5];
    extremes = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001};
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        sample_words_q.push_back(16'($urandom));
        cnt++;
      end else if (kind < 70) begin
        // drive every tap toward (or against) the sign of its coefficient to saturate
        for (int k = 0; k < NumTaps; k++) begin
          level = 16'($urandom_range(0, 255));
          if ((FirCoef[k] >= 0) ^ (kind >= 60)) level = 16'hFFFF - level;
          sample_words_q.push_back(level);
          cnt++;
        end
      end else if (kind < 85) begin
        level = 16'($urandom);
        len   = $urandom_range(8, 40);
        repeat (len) sample_words_q.push_back(level);
        cnt += len;
      end else if (kind < 95) begin
        sample_words_q.push_back(extremes[$urandom_range(0, 4)]);
        cnt++;
      end else begin
        s = int'(threshold_shadow) + $urandom_range(0, 4) - 2;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        sample_words_q.push_back(16'(s + 32768));
        cnt++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sample_ch.valid && !req_taken) begin
      end else if (send_gap > 0) begin
        send_gap--;
        sample_ch.valid <= 1'b0;
      end else if (sample_words_q.size() != 0) begin
        sample_ch.valid       <= 1'b1;
        sample_ch.sample_word <= sample_words_q.pop_front();
        send_gap = no_idle ? 0 : gap_len();
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LongHold;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        stall_left = no_idle ? 0 : gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    fir_result_t exp_res;
    req_taken = sample_ch.valid && sample_ch.ready;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          RegPwmCenter:      center_shadow    = pwdata[15:0];
          RegLevelThreshold: threshold_shadow = pwdata[15:0];
          default: ;
        endcase
      end
      if (req_taken) predicted_q.push_back(filter_and_compare(sample_ch.sample_word));
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result expected none actual filtered_sample %0d", $time,
                   result_ch.filtered_sample);
        end else begin
          exp_res = predicted_q.pop_front();
          check_field("filtered_sample", int'(exp_res.filtered_sample),
                      int'(result_ch.filtered_sample));
          check_field("compare_high", int'(exp_res.compare_high), int'(result_ch.compare_high));
          check_field("compare_low", int'(exp_res.compare_low), int'(result_ch.compare_low));
          check_field("over_level", int'(exp_res.over_level), int'(result_ch.over_level));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable && pwrite && pready) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.sample_word = '0;
    result_ch.ready       = 1'b0;
    no_idle               = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, division rounding, threshold edges, impulse response
    sample_words_q = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001, 16'h8004,
                       16'h8005, 16'h7FFB, 16'h7FFA, 16'h8000 + 16'd13999,
                       16'h8000 + 16'd14000, 16'h8000 + 16'd14001, 16'hFFFF,
                       16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
                       16'h8000, 16'h8000, 16'h8000};
    wait_results_drained();

    reg_write(AddrPwmCenter, 32'h0000_0000);
    reg_write(AddrLevelThreshold, 32'h0000_8000);
    push_burst(280);
    wait_results_drained();

    // back-to-back requests while the output is held off
    reg_write(AddrPwmCenter, 32'h0000_FFFF);
    reg_write(AddrLevelThreshold, 32'h0000_7FFF);
    no_idle = 1'b1;
    push_burst(300);
    hold_req++;
    wait_results_drained();
    no_idle = 1'b0;

    reg_write(AddrPwmCenter, 32'hFFFF_8000);
    reg_write(AddrLevelThreshold, 32'hA5A5_0000);
    push_burst(150);
    wait_results_drained();
    push_burst(150);
    wait_results_drained();

    repeat (3) begin
      reg_write(AddrPwmCenter, $urandom);
      reg_write(AddrLevelThreshold, $urandom);
      push_burst(260);
      wait_results_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && predicted_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
